### rtl/swd_pkg.sv
// shared types and constants for the startup watchdog
// used by swd_core and startup_watchdog_soft_hard_unit; no dependencies
`default_nettype none

package swd_pkg;

  localparam int TIME_BITS  = 48;
  localparam int SUM_BITS   = TIME_BITS + 1;
  localparam int TOKEN_BITS = 64;
  localparam int GEN_BITS   = 32;
  localparam int TAG_BITS   = 64;
  localparam int STAGE_BITS = 4;
  localparam int LIMIT_BITS = 32;
  localparam int OP_BITS    = 3;
  localparam int KIND_BITS  = 2;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = LIMIT_BITS;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOFT_DELAY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INACT_LIM  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ABS_LIM    = 2'd2;

  // input tdata layout, lowest field first
  localparam int IN_NOW_LSB   = 0;
  localparam int IN_LIFE_LSB  = IN_NOW_LSB + TIME_BITS;
  localparam int IN_GEN_LSB   = IN_LIFE_LSB + TOKEN_BITS;
  localparam int IN_PLAY_LSB  = IN_GEN_LSB + GEN_BITS;
  localparam int IN_TAG_LSB   = IN_PLAY_LSB + TOKEN_BITS;
  localparam int IN_STAGE_LSB = IN_TAG_LSB + TAG_BITS;
  localparam int IN_RAW_BITS  = IN_STAGE_LSB + STAGE_BITS;
  localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;

  // output tdata layout, lowest field first
  localparam int OUT_RAW_BITS  = 1 + TOKEN_BITS + GEN_BITS + TOKEN_BITS + TAG_BITS + STAGE_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_RAW_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_BEGIN    = 3'd0,
    OP_ADVANCE  = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_CANCEL   = 3'd3,
    OP_RESET    = 3'd4,
    OP_POLL     = 3'd5,
    OP_ACK      = 3'd6
  } op_t;

  typedef enum logic [KIND_BITS-1:0] {
    SIG_NONE    = 2'd0,
    SIG_DELAYED = 2'd1,
    SIG_TIMEOUT = 2'd2
  } sig_kind_t;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [TIME_BITS-1:0]  now_ms;
    logic [TOKEN_BITS-1:0] life_token;
    logic [GEN_BITS-1:0]   gen_number;
    logic [TOKEN_BITS-1:0] play_token;
    logic [TAG_BITS-1:0]   request_tag;
    logic [STAGE_BITS-1:0] stage_in;
  } swd_item_t;

  typedef struct packed {
    logic                  ok;
    sig_kind_t             kind;
    logic [TOKEN_BITS-1:0] life_token;
    logic [GEN_BITS-1:0]   gen_number;
    logic [TOKEN_BITS-1:0] play_token;
    logic [TAG_BITS-1:0]   request_tag;
    logic [STAGE_BITS-1:0] stage;
  } swd_res_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] soft_delay_ms;
    logic [LIMIT_BITS-1:0] inactivity_limit_ms;
    logic [LIMIT_BITS-1:0] absolute_limit_ms;
  } swd_cfg_t;

endpackage

`default_nettype wire

### rtl/swd_core.sv
// attempt state and per-transaction decision logic of the startup watchdog
// depends on swd_pkg
`default_nettype none

module swd_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire swd_pkg::swd_item_t item,
  input  wire swd_pkg::swd_cfg_t  cfg,
  output swd_pkg::swd_res_t       res
);
  import swd_pkg::*;

  logic                  active_r, active_nxt;
  logic [TOKEN_BITS-1:0] life_r, life_nxt;
  logic [GEN_BITS-1:0]   gen_r, gen_nxt;
  logic [TOKEN_BITS-1:0] play_r, play_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [STAGE_BITS-1:0] stage_r, stage_nxt;
  logic [TIME_BITS-1:0]  started_r, started_nxt;
  logic [TIME_BITS-1:0]  progress_r, progress_nxt;
  logic                  tmo_sent_r, tmo_sent_nxt;
  logic                  dly_sent_r, dly_sent_nxt;

  logic                  token_ok;
  logic                  time_ok;
  logic                  begin_ok;
  logic                  bind_match;
  logic [SUM_BITS-1:0]   inact_dl;
  logic [SUM_BITS-1:0]   abs_dl;
  logic [SUM_BITS-1:0]   soft_dl;
  logic [SUM_BITS-1:0]   hard_dl;
  logic [SUM_BITS-1:0]   now_ext;

  // deadlines one bit wider than time so they never wrap
  assign now_ext  = {1'b0, item.now_ms};
  assign inact_dl = {1'b0, progress_r} + SUM_BITS'(cfg.inactivity_limit_ms);
  assign abs_dl   = {1'b0, started_r} + SUM_BITS'(cfg.absolute_limit_ms);
  assign soft_dl  = {1'b0, started_r} + SUM_BITS'(cfg.soft_delay_ms);
  assign hard_dl  = (inact_dl < abs_dl) ? inact_dl : abs_dl;

  assign token_ok = active_r && (item.play_token != '0) && (item.play_token == play_r);
  assign time_ok  = item.now_ms >= started_r;
  assign begin_ok = (item.life_token != '0) && (item.gen_number != '0) &&
                    (item.play_token != '0) && (item.request_tag != '0) &&
                    (cfg.inactivity_limit_ms != '0) && (cfg.absolute_limit_ms != '0);
  assign bind_match = (item.life_token == life_r) && (item.gen_number == gen_r) &&
                      (item.play_token == play_r) && (item.request_tag == tag_r);

  always_comb begin
    res          = '0;
    active_nxt   = active_r;
    life_nxt     = life_r;
    gen_nxt      = gen_r;
    play_nxt     = play_r;
    tag_nxt      = tag_r;
    stage_nxt    = stage_r;
    started_nxt  = started_r;
    progress_nxt = progress_r;
    tmo_sent_nxt = tmo_sent_r;
    dly_sent_nxt = dly_sent_r;
    case (item.op)
      OP_BEGIN: begin
        if (begin_ok) begin
          active_nxt   = 1'b1;
          life_nxt     = item.life_token;
          gen_nxt      = item.gen_number;
          play_nxt     = item.play_token;
          tag_nxt      = item.request_tag;
          stage_nxt    = '0;
          started_nxt  = item.now_ms;
          progress_nxt = item.now_ms;
          tmo_sent_nxt = 1'b0;
          dly_sent_nxt = 1'b0;
          res.ok       = 1'b1;
        end
      end
      OP_ADVANCE: begin
        if (token_ok && time_ok && !tmo_sent_r && (item.stage_in > stage_r)) begin
          stage_nxt    = item.stage_in;
          progress_nxt = item.now_ms;
          res.ok       = 1'b1;
        end
      end
      OP_COMPLETE: begin
        if (token_ok && !tmo_sent_r) begin
          res.ok          = 1'b1;
          res.life_token  = life_r;
          res.gen_number  = gen_r;
          res.play_token  = play_r;
          res.request_tag = tag_r;
          active_nxt      = 1'b0;
        end
      end
      OP_CANCEL: begin
        if (token_ok) begin
          res.ok     = 1'b1;
          active_nxt = 1'b0;
        end
      end
      OP_RESET: begin
        res.ok     = 1'b1;
        active_nxt = 1'b0;
      end
      OP_POLL: begin
        if (active_r && time_ok) begin
          if (now_ext >= hard_dl) begin
            tmo_sent_nxt = 1'b1;
            res.kind     = SIG_TIMEOUT;
          end else if (!dly_sent_r && (now_ext >= soft_dl)) begin
            dly_sent_nxt = 1'b1;
            res.kind     = SIG_DELAYED;
          end
          if (res.kind != SIG_NONE) begin
            res.ok          = 1'b1;
            res.life_token  = life_r;
            res.gen_number  = gen_r;
            res.play_token  = play_r;
            res.request_tag = tag_r;
            res.stage       = stage_r;
          end
        end
      end
      OP_ACK: begin
        if (active_r && tmo_sent_r && bind_match) begin
          res.ok     = 1'b1;
          active_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // closing an attempt returns every held field to its reset value
    if (!active_nxt) begin
      life_nxt     = '0;
      gen_nxt      = '0;
      play_nxt     = '0;
      tag_nxt      = '0;
      stage_nxt    = '0;
      started_nxt  = '0;
      progress_nxt = '0;
      tmo_sent_nxt = 1'b0;
      dly_sent_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      life_r     <= '0;
      gen_r      <= '0;
      play_r     <= '0;
      tag_r      <= '0;
      stage_r    <= '0;
      started_r  <= '0;
      progress_r <= '0;
      tmo_sent_r <= 1'b0;
      dly_sent_r <= 1'b0;
    end else if (fire) begin
      active_r   <= active_nxt;
      life_r     <= life_nxt;
      gen_r      <= gen_nxt;
      play_r     <= play_nxt;
      tag_r      <= tag_nxt;
      stage_r    <= stage_nxt;
      started_r  <= started_nxt;
      progress_r <= progress_nxt;
      tmo_sent_r <= tmo_sent_nxt;
      dly_sent_r <= dly_sent_nxt;
    end
  end

  a_sent_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    (tmo_sent_r || dly_sent_r) |-> active_r)
    else $error("sent flag set without an open attempt");

  a_reset_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.op == OP_RESET) |=> !active_r)
    else $error("reset transaction left the attempt open");

  a_timeout_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.kind == SIG_TIMEOUT) |=> tmo_sent_r)
    else $error("timeout reported but not recorded");

  a_signal_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.kind != SIG_NONE) |-> (res.ok && item.op == OP_POLL))
    else $error("signal raised outside an accepted poll");

endmodule

`default_nettype wire

### rtl/startup_watchdog_soft_hard_unit.sv
// top level of the startup watchdog: stream ports, config registers, pipeline
// depends on swd_pkg and swd_core
`default_nettype none

// Startup watchdog for one startup attempt bound to a lifecycle token, a
// generation, a playback token and a request tag. Every input transaction
// yields exactly one result transaction. The block takes one transaction per
// clock as long as the output side keeps taking results: a transaction is held
// in an input register, the decision logic in swd_core evaluates it against the
// held attempt and moves it into the output register while updating the attempt
// state, and a new transaction enters the input register at the same time.
// With the output stalled the input register and output register hold one
// transaction each. Deadlines are rebuilt on each poll from the current limit
// registers (three 49-bit adds and compares, the path that sets the clock).
// The user must write limits through the cfg port only while no transaction
// is in flight; the block itself does not enforce this.
module startup_watchdog_soft_hard_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // now_ms, life_token, gen_number, play_token, request_tag, stage_in, zero pad
  input  wire logic [swd_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // opcode
  input  wire logic [swd_pkg::OP_BITS-1:0]       in_tuser,
  // result stream
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // ok, out_life_token, out_gen_number, out_play_token, out_request_tag, out_stage, zero pad
  output      logic [swd_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // signal_kind
  output      logic [swd_pkg::KIND_BITS-1:0]     out_tuser,
  // configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [swd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [swd_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import swd_pkg::*;

  swd_cfg_t  cfg_r;
  logic      s1_valid_r, s1_valid_nxt;
  swd_item_t s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  swd_res_t  out_res_r;
  swd_res_t  core_res;
  swd_item_t in_item;
  logic      fire;
  logic      in_take;

  // unpack the incoming transaction
  always_comb begin
    in_item.op          = in_tuser;
    in_item.now_ms      = in_tdata[IN_NOW_LSB   +: TIME_BITS];
    in_item.life_token  = in_tdata[IN_LIFE_LSB  +: TOKEN_BITS];
    in_item.gen_number  = in_tdata[IN_GEN_LSB   +: GEN_BITS];
    in_item.play_token  = in_tdata[IN_PLAY_LSB  +: TOKEN_BITS];
    in_item.request_tag = in_tdata[IN_TAG_LSB   +: TAG_BITS];
    in_item.stage_in    = in_tdata[IN_STAGE_LSB +: STAGE_BITS];
  end

  // the held transaction is evaluated when the output register is free or draining
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;
  assign in_take   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_tready);

  // configuration registers, no read-back; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOFT_DELAY: cfg_r.soft_delay_ms       <= cfg_wdata;
        CFG_INACT_LIM:  cfg_r.inactivity_limit_ms <= cfg_wdata;
        CFG_ABS_LIM:    cfg_r.absolute_limit_ms   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  swd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {{OUT_PAD_BITS{1'b0}},
                       out_res_r.stage,
                       out_res_r.request_tag,
                       out_res_r.play_token,
                       out_res_r.gen_number,
                       out_res_r.life_token,
                       out_res_r.ok};

endmodule

`default_nettype wire
